[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check a condition that must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/adeq_pkg.sv]
// Types and codes shared by the array deque modules
`timescale 1ns / 1ps
`default_nettype none

package adeq_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef enum logic [1:0] {
        KIND_INS_REAR = 2'd0,
        KIND_INS_FRONT = 2'd1,
        KIND_REM_REAR = 2'd2,
        KIND_REM_FRONT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_DONE = 2'd0,
        STATUS_NO_ROOM = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic accept;
        logic load_rd;
    } t_dp_cmd;

    typedef struct packed {
        logic need_read;
    } t_dp_stat;

endpackage

`default_nettype wire

[hw/rtl/adeq_ctrl.sv]
// Controller state machine: request handshake, slot read sequencing, output valid
`timescale 1ns / 1ps
`default_nettype none

module adeq_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  wire                i_m_tready,
    input  adeq_pkg::t_dp_stat i_stat,
    output adeq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   load;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign load       = (accept && !i_stat.need_read) || (r_state == ST_READ);

    assign o_cmd.accept  = accept;
    assign o_cmd.load_rd = (r_state == ST_READ);
    assign o_m_tvalid    = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_stat.need_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/adeq_datapath.sv]
// Datapath: slot memory, head and tail indices, empty flag, result register
`timescale 1ns / 1ps
`default_nettype none

module adeq_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  adeq_pkg::t_dp_cmd                i_cmd,
    input  wire [1:0]                        i_kind,
    input  wire [adeq_pkg::VALUE_W-1:0]      i_value,
    output adeq_pkg::t_dp_stat               o_stat,
    output logic [1:0]                       o_status,
    output logic [adeq_pkg::VALUE_W-1:0]     o_removed
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [adeq_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [adeq_pkg::VALUE_W-1:0] r_rdata;

    logic [AW-1:0]           r_head, n_head;
    logic [AW-1:0]           r_tail, n_tail;
    logic                    r_empty, n_empty;
    logic [1:0]              r_status;
    logic [adeq_pkg::VALUE_W-1:0] r_removed;

    logic                    we;
    logic [AW-1:0]           waddr;
    logic                    re;
    logic [AW-1:0]           raddr;
    adeq_pkg::t_status       imm_status;

    assign o_stat.need_read = i_kind[1] && !r_empty;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_empty    = r_empty;
        we         = 1'b0;
        waddr      = '0;
        re         = 1'b0;
        raddr      = r_tail;
        imm_status = adeq_pkg::STATUS_DONE;
        case (adeq_pkg::t_kind'(i_kind))
            adeq_pkg::KIND_INS_REAR: begin
                if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    we      = 1'b1;
                end else if (r_tail == LAST) begin
                    imm_status = adeq_pkg::STATUS_NO_ROOM;
                end else begin
                    n_tail = r_tail + AW'(1);
                    we     = 1'b1;
                    waddr  = r_tail + AW'(1);
                end
            end
            adeq_pkg::KIND_INS_FRONT: begin
                if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    we      = 1'b1;
                end else if (r_head == '0) begin
                    imm_status = adeq_pkg::STATUS_NO_ROOM;
                end else begin
                    n_head = r_head - AW'(1);
                    we     = 1'b1;
                    waddr  = r_head - AW'(1);
                end
            end
            adeq_pkg::KIND_REM_REAR, adeq_pkg::KIND_REM_FRONT: begin
                if (r_empty) begin
                    imm_status = adeq_pkg::STATUS_EMPTY;
                end else begin
                    re    = 1'b1;
                    raddr = i_kind[0] ? r_head : r_tail;
                    if (r_head == r_tail) begin
                        n_empty = 1'b1;
                        n_head  = '0;
                        n_tail  = '0;
                    end else if (!i_kind[0]) begin
                        n_tail = r_tail - AW'(1);
                    end else begin
                        n_head = r_head + AW'(1);
                    end
                end
            end
            default: begin
                imm_status = adeq_pkg::STATUS_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && we) begin
            mem[waddr] <= i_value;
        end
        if (i_cmd.accept && re) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rd) begin
            r_status  <= adeq_pkg::STATUS_DONE;
            r_removed <= r_rdata;
        end else if (i_cmd.accept && !o_stat.need_read) begin
            r_status  <= imm_status;
            r_removed <= '0;
        end
    end

    assign o_status  = r_status;
    assign o_removed = r_removed;

endmodule

`default_nettype wire

[hw/rtl/array_double_ended_queue_top.sv]
// Array deque top level: stream ports, controller and datapath
// A fixed-array double-ended queue of DEPTH signed 32-bit slots that never wraps.
// Each request beat carries a kind in tuser and a value in tdata and returns one
// result beat with a status and the removed value. Inserts and failed requests are
// answered straight into the result register; a successful removal first reads its
// slot through the registered read port. The result register lets the next request
// enter in the cycle its result is taken. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module array_double_ended_queue_top #(
    parameter int unsigned DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [31:0] value
    input  wire  [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata    // [1:0] status, [33:2] removed_value, zero above
);

    adeq_pkg::t_dp_cmd  cmd;
    adeq_pkg::t_dp_stat stat;
    logic [1:0]         status;
    logic [31:0]        removed;

    adeq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    adeq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_kind    (i_s_tuser),
        .i_value   (i_s_tdata),
        .o_stat    (stat),
        .o_status  (status),
        .o_removed (removed)
    );

    assign o_m_tdata = {6'd0, removed, status};

    `ASSERT_CLK(a_imm_result, cmd.accept && !stat.need_read |=> o_m_tvalid, "result beat missing")
    `ASSERT_CLK(a_read_next, cmd.accept && stat.need_read |=> cmd.load_rd && !o_s_tready,
        "read cycle missing")
    `ASSERT_CLK(a_read_result, cmd.load_rd |=> o_m_tvalid, "removal result missing")
    `ASSERT_NEVER(a_read_overwrite, cmd.load_rd && o_m_tvalid, "result overwritten by read")

endmodule

`default_nettype wire
